[src/pls_pkg.sv]
package pls_pkg;

	localparam int DEF_DEPTH        = 16;
	localparam int DEF_KEY_BITS     = 16;
	localparam int DEF_PAYLOAD_BITS = 32;

	localparam int REQ_W = 2;
	localparam int POS_W = 5;
	localparam int KEY_W = 16;
	localparam int PAY_W = 32;
	localparam int CNT_W = 5;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [POS_W-1:0] position;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} req_t;

	typedef struct packed {
		logic             accepted;
		logic             found;
		logic [KEY_W-1:0] found_key;
		logic [PAY_W-1:0] found_payload;
		logic [CNT_W-1:0] entry_count;
	} res_t;

endpackage

[src/pls_req_if.sv]
interface pls_req_if;
	logic                       valid;
	logic                       ready;
	logic [pls_pkg::REQ_W-1:0]  req_type;
	logic [pls_pkg::POS_W-1:0]  position;
	logic [pls_pkg::KEY_W-1:0]  key;
	logic [pls_pkg::PAY_W-1:0]  payload;

	modport source(output valid, req_type, position, key, payload, input ready);
	modport sink(input valid, req_type, position, key, payload, output ready);
endinterface

[src/pls_res_if.sv]
interface pls_res_if;
	logic                       valid;
	logic                       ready;
	logic                       accepted;
	logic                       found;
	logic [pls_pkg::KEY_W-1:0]  found_key;
	logic [pls_pkg::PAY_W-1:0]  found_payload;
	logic [pls_pkg::CNT_W-1:0]  entry_count;

	modport source(output valid, accepted, found, found_key, found_payload, entry_count,
		input ready);
	modport sink(input valid, accepted, found, found_key, found_payload, entry_count,
		output ready);
endinterface

[src/positional_list_store.sv]
// operation: insert moves the entries from the position up one slot, then writes the new one;
// remove moves the entries above the position down one slot; search reads from the front until
// a key matches or the list ends; a refused or unused request goes straight to the result step,
// and the last step waits while an earlier result is not taken
// throughput: one request at a time; ready is low from a request's transfer until its result is registered
// reset: arst_n clears the fill count, sequencer and output valid; entries are not cleared
module positional_list_store #(
	parameter int DEPTH        = pls_pkg::DEF_DEPTH,
	parameter int KEY_BITS     = pls_pkg::DEF_KEY_BITS,
	parameter int PAYLOAD_BITS = pls_pkg::DEF_PAYLOAD_BITS
) (
	input logic      clk,
	input logic      arst_n,
	pls_req_if.sink  req,
	pls_res_if.source rsp
);

	pls_pkg::req_t req_s;
	pls_pkg::res_t res;
	pls_pkg::res_t res_q;
	logic          rsp_valid_q;
	logic          idle;
	logic          done;
	logic          start;
	logic          out_free;

	assign req_s.req_type = req.req_type;
	assign req_s.position = req.position;
	assign req_s.key      = req.key;
	assign req_s.payload  = req.payload;

	assign req.ready = idle;
	assign start     = req.valid && idle;
	assign out_free  = !rsp_valid_q || rsp.ready;

	pls_ctrl #(
		.DEPTH       (DEPTH),
		.KEY_BITS    (KEY_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req_s),
		.out_free(out_free),
		.idle    (idle),
		.done    (done),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.accepted      = res_q.accepted;
	assign rsp.found         = res_q.found;
	assign rsp.found_key     = res_q.found_key;
	assign rsp.found_payload = res_q.found_payload;
	assign rsp.entry_count   = res_q.entry_count;

endmodule

[src/pls_ram.sv]
module pls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[src/pls_ctrl.sv]
module pls_ctrl #(
	parameter int DEPTH        = pls_pkg::DEF_DEPTH,
	parameter int KEY_BITS     = pls_pkg::DEF_KEY_BITS,
	parameter int PAYLOAD_BITS = pls_pkg::DEF_PAYLOAD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pls_pkg::req_t req,
	input  logic          out_free,
	output logic          idle,
	output logic          done,
	output pls_pkg::res_t res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W;
	localparam int EW = KEY_BITS + PAYLOAD_BITS;
	localparam int KW = pls_pkg::KEY_W;
	localparam int PW = pls_pkg::PAY_W;
	localparam int NW = pls_pkg::CNT_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_PUT  = 3'd2;
	localparam logic [2:0] S_REM  = 3'd3;
	localparam logic [2:0] S_SRCH = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]              state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           next_cnt_q;
	logic [CW-1:0]           ptr_q;
	logic [CW-1:0]           pos_q;
	logic [AW-1:0]           wa_q;
	logic                    pend_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic                    acc_q;
	logic                    found_q;
	logic [KEY_BITS-1:0]     fkey_q;
	logic [PAYLOAD_BITS-1:0] fpay_q;

	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [EW-1:0]           wr_data;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic [EW-1:0]           rd_data;
	logic [KEY_BITS-1:0]     rd_key;
	logic [PAYLOAD_BITS-1:0] rd_pay;
	logic [CW-1:0]           ptr_dec;
	logic [CW-1:0]           ptr_inc;
	logic [XW-1:0]           pos_x;
	logic [XW-1:0]           cnt_x;
	logic                    hit;

	pls_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_key  = rd_data[EW-1:PAYLOAD_BITS];
	assign rd_pay  = rd_data[PAYLOAD_BITS-1:0];
	assign ptr_dec = ptr_q - CW'(1);
	assign ptr_inc = ptr_q + CW'(1);
	assign pos_x   = XW'(req.position);
	assign cnt_x   = XW'(count_q);
	// single key comparator, shared by every search step
	assign hit     = pend_q && (rd_key == key_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wa_q;
		wr_data = rd_data;
		rd_en   = 1'b0;
		rd_addr = ptr_q[AW-1:0];
		case (state_q)
			S_INS: begin
				// read entry below the pointer, write the previous one a slot up
				wr_en = pend_q;
				if (ptr_q != pos_q) begin
					rd_en   = 1'b1;
					rd_addr = ptr_dec[AW-1:0];
				end
			end
			S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[AW-1:0];
				wr_data = {key_q, pay_q};
			end
			S_REM: begin
				wr_en = pend_q;
				rd_en = (ptr_q != count_q);
			end
			S_SRCH: begin
				rd_en = !hit && (ptr_q != count_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			next_cnt_q <= '0;
			ptr_q      <= '0;
			pend_q     <= 1'b0;
			acc_q      <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						pend_q     <= 1'b0;
						acc_q      <= 1'b0;
						found_q    <= 1'b0;
						next_cnt_q <= count_q;
						case (req.req_type)
							pls_pkg::REQ_INSERT: begin
								if (count_q != CW'(DEPTH) && pos_x <= cnt_x) begin
									ptr_q   <= count_q;
									state_q <= S_INS;
								end else begin
									state_q <= S_DONE;
								end
							end
							pls_pkg::REQ_REMOVE: begin
								if (pos_x != '0 && pos_x <= cnt_x) begin
									ptr_q   <= CW'(req.position);
									state_q <= S_REM;
								end else begin
									state_q <= S_DONE;
								end
							end
							pls_pkg::REQ_SEARCH: begin
								ptr_q   <= '0;
								state_q <= S_SRCH;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INS: begin
					pend_q <= (ptr_q != pos_q);
					if (ptr_q != pos_q) begin
						ptr_q <= ptr_dec;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					acc_q      <= 1'b1;
					next_cnt_q <= count_q + CW'(1);
					state_q    <= S_DONE;
				end
				S_REM: begin
					if (ptr_q != count_q) begin
						pend_q <= 1'b1;
						ptr_q  <= ptr_inc;
					end else begin
						// last pending move lands this cycle
						acc_q      <= 1'b1;
						next_cnt_q <= count_q - CW'(1);
						state_q    <= S_DONE;
					end
				end
				S_SRCH: begin
					if (hit) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else if (ptr_q == count_q) begin
						state_q <= S_DONE;
					end else begin
						pend_q <= 1'b1;
						ptr_q  <= ptr_inc;
					end
				end
				S_DONE: begin
					if (out_free) begin
						count_q <= next_cnt_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload side, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			key_q  <= KEY_BITS'(req.key);
			pay_q  <= PAYLOAD_BITS'(req.payload);
			pos_q  <= CW'(req.position);
			fkey_q <= '0;
			fpay_q <= '0;
		end
		if (state_q == S_INS) begin
			wa_q <= ptr_q[AW-1:0];
		end
		if (state_q == S_REM && ptr_q != count_q) begin
			wa_q <= ptr_dec[AW-1:0];
		end
		if (state_q == S_SRCH && hit) begin
			fkey_q <= rd_key;
			fpay_q <= rd_pay;
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE) && out_free;

	assign res.accepted      = acc_q;
	assign res.found         = found_q;
	assign res.found_key     = KW'(fkey_q);
	assign res.found_payload = PW'(fpay_q);
	assign res.entry_count   = NW'(next_cnt_q);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	a_put_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> (count_q != CW'(DEPTH)))
		else $error("new entry written into a full list");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !idle)
		else $error("request taken but sequencer stayed idle");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> $stable(count_q))
		else $error("fill count moved outside result transfer");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_free)
		else $error("result produced while output slot busy");

endmodule
